FILE: src/safespi_frame_codec_crc8_top_macros.svh
// ----------------------------------------------------------------------------
// SafeSPI frame codec assertion macros
// Shared concurrent assertion forms for the frame codec checkers.
// ----------------------------------------------------------------------------
`ifndef SAFESPI_FRAME_CODEC_CRC8_TOP_MACROS_SVH
`define SAFESPI_FRAME_CODEC_CRC8_TOP_MACROS_SVH

// Same-cycle implication, sampled on clk, idle during reset.
`define SFC_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("frame codec assertion failed");

// Next-cycle implication, sampled on clk, idle during reset.
`define SFC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("frame codec assertion failed");

`endif

FILE: src/sfc_pkg.sv
// ----------------------------------------------------------------------------
// SafeSPI frame codec package
// Frame layout constants, opcodes, result struct and the CRC-8 helpers.
// ----------------------------------------------------------------------------
package sfc_pkg;

  localparam int FRAME_W  = 48;
  localparam int CRC_W    = 8;
  localparam int CRC_BITS = FRAME_W - CRC_W;
  localparam int ADDR_LSB = 38;
  localparam int RW_BIT   = 37;
  localparam int FT_BIT   = 35;
  localparam int DATA_LSB = 8;

  localparam logic [CRC_W-1:0] CRC_POLY = 8'h2F;
  localparam logic [CRC_W-1:0] CRC_INIT = 8'hFF;

  typedef enum logic [1:0] {
    OP_READ  = 2'd0,
    OP_WRITE = 2'd1,
    OP_CHECK = 2'd2
  } opcode_t;

  // One result beat as it leaves the codec.
  typedef struct packed {
    logic [FRAME_W-1:0] frame;
    logic [CRC_W-1:0]   crc;
    logic               crc_ok;
    logic [15:0]        data_word;
    logic [19:0]        data_signed;
  } result_t;

  typedef logic [CRC_BITS-1:0][CRC_W-1:0] crc_col_t;

  // Bit-serial CRC, MSB first; only used to derive constants at elaboration.
  function automatic logic [CRC_W-1:0] crc_serial(logic [CRC_W-1:0] init,
                                                  logic [FRAME_W-1:0] bits);
    logic [CRC_W-1:0] r;
    r = init;
    for (int p = FRAME_W - 1; p >= 0; p--) begin
      if (r[CRC_W-1]) begin
        r = {r[CRC_W-2:0], 1'b0} ^ CRC_POLY ^ {{(CRC_W-1){1'b0}}, bits[p]};
      end else begin
        r = {r[CRC_W-2:0], bits[p]};
      end
    end
    return r;
  endfunction

  // Contribution of each data bit (frame bit i + 8) with a zero start value.
  function automatic crc_col_t build_cols();
    crc_col_t cols;
    for (int i = 0; i < CRC_BITS; i++) begin
      cols[i] = crc_serial({CRC_W{1'b0}}, {{(FRAME_W-1){1'b0}}, 1'b1} << (i + CRC_W));
    end
    return cols;
  endfunction

  localparam logic [CRC_W-1:0] CRC_BASE = crc_serial(CRC_INIT, {FRAME_W{1'b0}});
  localparam crc_col_t         CRC_COL  = build_cols();

  // The CRC is linear, so it is the start term XOR the columns of the set bits.
  function automatic logic [CRC_W-1:0] crc8_calc(logic [CRC_BITS-1:0] d);
    logic [CRC_W-1:0] acc;
    acc = CRC_BASE;
    for (int i = 0; i < CRC_BITS; i++) begin
      if (d[i]) begin
        acc = acc ^ CRC_COL[i];
      end
    end
    return acc;
  endfunction

endpackage

FILE: src/sfc_codec.sv
// ----------------------------------------------------------------------------
// SafeSPI frame codec datapath
// Builds read and write command frames or checks a response frame.
// ----------------------------------------------------------------------------
module sfc_codec (
  input  logic [1:0]                  opcode,
  input  logic [7:0]                  reg_address,
  input  logic [15:0]                 write_data,
  input  logic [sfc_pkg::FRAME_W-1:0] response_frame,
  output sfc_pkg::result_t            result
);

  logic [sfc_pkg::FRAME_W-1:0] head;
  logic [sfc_pkg::CRC_W-1:0]   crc;
  logic [sfc_pkg::FRAME_W-1:0] frame;
  logic                        is_check;

  // Assemble the frame bits above the CRC byte.
  always_comb begin
    head     = '0;
    is_check = 1'b0;
    unique case (opcode)
      sfc_pkg::OP_READ: begin
        head[sfc_pkg::ADDR_LSB +: 8] = reg_address;
        head[sfc_pkg::FT_BIT]        = 1'b1;
      end
      sfc_pkg::OP_WRITE: begin
        head[sfc_pkg::ADDR_LSB +: 8]  = reg_address;
        head[sfc_pkg::FT_BIT]         = 1'b1;
        head[sfc_pkg::RW_BIT]         = 1'b1;
        head[sfc_pkg::DATA_LSB +: 16] = write_data;
      end
      default: begin
        // Response check; the unused opcode is treated the same way.
        head     = response_frame;
        is_check = 1'b1;
      end
    endcase
  end

  // One CRC serves both paths: built frames carry it, responses compare with it.
  assign crc   = sfc_pkg::crc8_calc(head[sfc_pkg::FRAME_W-1:sfc_pkg::CRC_W]);
  assign frame = {head[sfc_pkg::FRAME_W-1:sfc_pkg::CRC_W],
                  is_check ? head[sfc_pkg::CRC_W-1:0] : crc};

  assign result.frame       = frame;
  assign result.crc         = crc;
  assign result.crc_ok      = (frame[sfc_pkg::CRC_W-1:0] == crc);
  assign result.data_word   = frame[sfc_pkg::DATA_LSB +: 16];
  assign result.data_signed = frame[sfc_pkg::DATA_LSB +: 20];

endmodule

FILE: src/safespi_frame_codec_crc8_top.sv
// ----------------------------------------------------------------------------
// SafeSPI 48-bit frame codec with CRC-8
// Two-stage pipeline around a single-pass frame build and CRC check.
// ----------------------------------------------------------------------------
//  Channel  Direction  Handshake            Payload
//  in_      input      in_valid/in_ready    opcode, reg_address, write_data,
//                                           response_frame
//  out_     output     out_valid/out_ready  frame_out, crc_value, crc_ok,
//                                           data_word, data_signed
//
// One beat is accepted every cycle while the output is not stalled; a result
// passes through the input register and then the result register.
// The CRC is an XOR tree between those registers.
// Reset (synchronous, active low) clears only the two valid flags.
// A stalled output holds its beat and the input register refills behind it.
module safespi_frame_codec_crc8_top (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [1:0]                  in_opcode,
  input  logic [7:0]                  in_reg_address,
  input  logic [15:0]                 in_write_data,
  input  logic [sfc_pkg::FRAME_W-1:0] in_response_frame,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [sfc_pkg::FRAME_W-1:0] out_frame_out,
  output logic [sfc_pkg::CRC_W-1:0]   out_crc_value,
  output logic                        out_crc_ok,
  output logic [15:0]                 out_data_word,
  output logic signed [19:0]          out_data_signed
);

  logic                        s1_valid_r, s1_valid_nxt;
  logic [1:0]                  s1_opcode_r;
  logic [7:0]                  s1_addr_r;
  logic [15:0]                 s1_wdata_r;
  logic [sfc_pkg::FRAME_W-1:0] s1_resp_r;
  logic                        out_valid_r, out_valid_nxt;
  sfc_pkg::result_t            out_res_r;
  sfc_pkg::result_t            codec_res;
  logic                        out_adv;

  // Pipeline flow: the result register moves when empty or taken.
  assign out_adv  = !out_valid_r || out_ready;
  assign in_ready = !s1_valid_r || out_adv;

  always_comb begin
    s1_valid_nxt  = s1_valid_r;
    out_valid_nxt = out_valid_r;
    if (in_ready) begin
      s1_valid_nxt = in_valid;
    end
    if (out_adv) begin
      out_valid_nxt = s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Input register captures an accepted beat.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_opcode_r <= in_opcode;
      s1_addr_r   <= in_reg_address;
      s1_wdata_r  <= in_write_data;
      s1_resp_r   <= in_response_frame;
    end
  end

  sfc_codec u_codec (
    .opcode         (s1_opcode_r),
    .reg_address    (s1_addr_r),
    .write_data     (s1_wdata_r),
    .response_frame (s1_resp_r),
    .result         (codec_res)
  );

  // Result register loads when the held beat moves on.
  always_ff @(posedge clk) begin
    if (out_adv && s1_valid_r) begin
      out_res_r <= codec_res;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_frame_out   = out_res_r.frame;
  assign out_crc_value   = out_res_r.crc;
  assign out_crc_ok      = out_res_r.crc_ok;
  assign out_data_word   = out_res_r.data_word;
  assign out_data_signed = out_res_r.data_signed;

endmodule

FILE: src/sfc_checker.sv
// ----------------------------------------------------------------------------
// SafeSPI frame codec checker
// Port-level assertions on result beats, bound to the top level.
// ----------------------------------------------------------------------------
`include "safespi_frame_codec_crc8_top_macros.svh"

module sfc_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [sfc_pkg::FRAME_W-1:0] out_frame_out,
  input logic [sfc_pkg::CRC_W-1:0]   out_crc_value,
  input logic                        out_crc_ok,
  input logic [15:0]                 out_data_word,
  input logic signed [19:0]          out_data_signed
);

  // A stalled result beat stays offered.
  `SFC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)

  // The check flag agrees with the frame's CRC byte.
  `SFC_ASSERT_NOW(a_crc_ok, out_valid, out_crc_ok == (out_frame_out[7:0] == out_crc_value))

  // Both data views come from the same frame bits.
  `SFC_ASSERT_NOW(a_data_word, out_valid, out_data_word == out_frame_out[23:8])
  `SFC_ASSERT_NOW(a_data_signed, out_valid, out_data_signed == out_frame_out[27:8])

  // With the output free, the input side never stalls.
  `SFC_ASSERT_NOW(a_no_stall, !out_valid, in_ready)

endmodule

bind safespi_frame_codec_crc8_top sfc_checker u_sfc_checker (.*);

FILE: tb/tb_safespi_frame_codec_crc8_top.sv
// ----------------------------------------------------------------------------
// Testbench for the SafeSPI 48-bit frame codec with CRC-8
// Builds read and write command frames and checks response frames, predicts
// every result beat in the testbench and compares it with the block output,
// under random sender bursts, receiver stalls and one long output hold-off.
// ----------------------------------------------------------------------------
module tb_safespi_frame_codec_crc8_top;

  // Opcode 3 is not decoded separately; bit 1 alone selects a response check.
  localparam logic [1:0] OP_SPARE    = 2'd3;
  localparam int         HOLD_CYCLES = 300;
  localparam int         DRAIN_LIMIT = 20000;
  localparam int         TAIL_CYCLES = 6;

  typedef enum int {RDY_ALWAYS, RDY_PATTERN, RDY_HEAVY} ready_mode_t;

  logic                        clk;
  logic                        rst_n;
  logic                        in_valid;
  logic                        in_ready;
  logic [1:0]                  in_opcode;
  logic [7:0]                  in_reg_address;
  logic [15:0]                 in_write_data;
  logic [sfc_pkg::FRAME_W-1:0] in_response_frame;
  logic                        out_valid;
  logic                        out_ready;
  logic [sfc_pkg::FRAME_W-1:0] out_frame_out;
  logic [sfc_pkg::CRC_W-1:0]   out_crc_value;
  logic                        out_crc_ok;
  logic [15:0]                 out_data_word;
  logic signed [19:0]          out_data_signed;

  sfc_pkg::result_t results_due[$];
  sfc_pkg::result_t want;
  int               fail_count;
  int               beats_checked;
  int               crc_good_seen;
  int               crc_bad_seen;
  int               input_stall_cycles;
  int               op_sent[4];
  ready_mode_t      ready_mode;
  bit               hold_req;
  int               hold_left;
  int               run_left;
  bit               run_ready;

  safespi_frame_codec_crc8_top i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_opcode         (in_opcode),
    .in_reg_address    (in_reg_address),
    .in_write_data     (in_write_data),
    .in_response_frame (in_response_frame),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_frame_out     (out_frame_out),
    .out_crc_value     (out_crc_value),
    .out_crc_ok        (out_crc_ok),
    .out_data_word     (out_data_word),
    .out_data_signed   (out_data_signed)
  );

  // Clock with a period of two time units.
  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Serial CRC-8, MSB first, over bits 47..8 followed by eight zero bits.
  function automatic logic [sfc_pkg::CRC_W-1:0] frame_crc8(logic [sfc_pkg::FRAME_W-1:0] f);
    logic [sfc_pkg::CRC_W-1:0] r;
    logic                      b;
    r = sfc_pkg::CRC_INIT;
    for (int p = sfc_pkg::FRAME_W - 1; p >= 0; p--) begin
      b = (p >= sfc_pkg::CRC_W) ? f[p] : 1'b0;
      if (r[sfc_pkg::CRC_W-1]) begin
        r = {r[sfc_pkg::CRC_W-2:0], 1'b0} ^ sfc_pkg::CRC_POLY ^
            {{(sfc_pkg::CRC_W-1){1'b0}}, b};
      end else begin
        r = {r[sfc_pkg::CRC_W-2:0], b};
      end
    end
    return r;
  endfunction

  // Expected result beat for one input beat.
  function automatic sfc_pkg::result_t predict_codec_result(logic [1:0] op,
                                                            logic [7:0] addr,
                                                            logic [15:0] wdata,
                                                            logic [sfc_pkg::FRAME_W-1:0] rsp);
    sfc_pkg::result_t            r;
    logic [sfc_pkg::FRAME_W-1:0] f;
    if (op[1]) begin
      f = rsp;
    end else begin
      f = '0;
      f[sfc_pkg::ADDR_LSB +: 8] = addr;
      f[sfc_pkg::FT_BIT] = 1'b1;
      if (op == sfc_pkg::OP_WRITE) begin
        f[sfc_pkg::RW_BIT] = 1'b1;
        f[sfc_pkg::DATA_LSB +: 16] = wdata;
      end
      f[sfc_pkg::CRC_W-1:0] = frame_crc8(f);
    end
    r.frame       = f;
    r.crc         = frame_crc8(f);
    r.crc_ok      = (f[sfc_pkg::CRC_W-1:0] == r.crc);
    r.data_word   = f[sfc_pkg::DATA_LSB +: 16];
    r.data_signed = f[sfc_pkg::DATA_LSB +: 20];
    return r;
  endfunction

  function automatic logic [sfc_pkg::FRAME_W-1:0] random_frame();
    logic [63:0] w;
    w = {$urandom(), $urandom()};
    return w[sfc_pkg::FRAME_W-1:0];
  endfunction

  // Given frame with its low byte replaced by the correct CRC.
  function automatic logic [sfc_pkg::FRAME_W-1:0] good_frame(logic [sfc_pkg::FRAME_W-1:0] f);
    logic [sfc_pkg::FRAME_W-1:0] g;
    g = f;
    g[sfc_pkg::CRC_W-1:0] = frame_crc8(g);
    return g;
  endfunction

  // Offer one beat and hold it until the block takes it.
  task automatic send_beat(logic [1:0] op, logic [7:0] addr, logic [15:0] wdata,
                           logic [sfc_pkg::FRAME_W-1:0] rsp);
    @(negedge clk);
    in_valid          <= 1'b1;
    in_opcode         <= op;
    in_reg_address    <= addr;
    in_write_data     <= wdata;
    in_response_frame <= rsp;
    results_due.push_back(predict_codec_result(op, addr, wdata, rsp));
    op_sent[op]++;
    do @(posedge clk); while (!in_ready);
  endtask

  // Idle the sender with junk on the payload.
  task automatic idle_gap(int n);
    repeat (n) begin
      @(negedge clk);
      in_valid          <= 1'b0;
      in_opcode         <= 2'($urandom());
      in_reg_address    <= 8'($urandom());
      in_write_data     <= 16'($urandom());
      in_response_frame <= random_frame();
    end
  endtask

  // Let all outstanding results arrive, then idle for a quiet tail.
  task automatic wait_drain();
    int cnt;
    cnt = 0;
    idle_gap(1);
    while (results_due.size() != 0 && cnt < DRAIN_LIMIT) begin
      @(posedge clk);
      cnt++;
    end
    if (results_due.size() != 0) begin
      fail_count++;
      if (fail_count <= 10) begin
        $display("ERROR: %0d result beats never arrived", results_due.size());
      end
      $display("Some tests failed");
      $finish;
    end else begin
      repeat (TAIL_CYCLES) @(posedge clk);
    end
  endtask

  task automatic check_field(string fname, logic [sfc_pkg::FRAME_W-1:0] exp_v,
                             logic [sfc_pkg::FRAME_W-1:0] got_v);
    if (exp_v !== got_v) begin
      fail_count++;
      if (fail_count <= 10) begin
        $display("ERROR: %s expected 0x%0h got 0x%0h", fname, exp_v, got_v);
      end
    end
  endtask

  // Result checker: every accepted output beat against the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_ready) begin
      input_stall_cycles++;
    end
    if (rst_n && out_valid && out_ready) begin
      if (results_due.size() == 0) begin
        fail_count++;
        if (fail_count <= 10) begin
          $display("ERROR: result beat 0x%0h with nothing expected", out_frame_out);
        end
      end else begin
        want = results_due.pop_front();
        check_field("frame_out", want.frame, out_frame_out);
        check_field("crc_value", 48'(want.crc), 48'(out_crc_value));
        check_field("crc_ok", 48'(want.crc_ok), 48'(out_crc_ok));
        check_field("data_word", 48'(want.data_word), 48'(out_data_word));
        check_field("data_signed", 48'(want.data_signed), 48'($unsigned(out_data_signed)));
        beats_checked++;
        if (out_crc_ok) begin
          crc_good_seen++;
        end else begin
          crc_bad_seen++;
        end
      end
    end
  end

  // Receiver: alternating ready and stall runs, plus the long hold-off on request.
  always @(negedge clk) begin
    if (hold_req) begin
      hold_req  = 1'b0;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      if (run_left == 0) begin
        run_ready = !run_ready;
        if (run_ready) begin
          run_left = (ready_mode == RDY_HEAVY) ? $urandom_range(1, 6) : $urandom_range(1, 16);
        end else begin
          run_left = (ready_mode == RDY_HEAVY) ? $urandom_range(1, 30) : $urandom_range(1, 4);
        end
      end
      run_left--;
      out_ready <= (ready_mode == RDY_ALWAYS) ? 1'b1 : run_ready;
    end
  end

  // Read commands at the address extremes and two patterns; the unused fields are all ones, zeros or random.
  task automatic test_read_commands();
    send_beat(sfc_pkg::OP_READ, 8'h00, 16'hFFFF, {sfc_pkg::FRAME_W{1'b1}});
    send_beat(sfc_pkg::OP_READ, 8'hFF, 16'hFFFF, {sfc_pkg::FRAME_W{1'b1}});
    send_beat(sfc_pkg::OP_READ, 8'hAA, 16'h0000, '0);
    send_beat(sfc_pkg::OP_READ, 8'h55, 16'h1234, random_frame());
    idle_gap(1);
  endtask

  // Write commands at the address and data extremes.
  task automatic test_write_commands();
    send_beat(sfc_pkg::OP_WRITE, 8'h00, 16'h0000, {sfc_pkg::FRAME_W{1'b1}});
    send_beat(sfc_pkg::OP_WRITE, 8'hFF, 16'hFFFF, '0);
    send_beat(sfc_pkg::OP_WRITE, 8'h55, 16'hAAAA, random_frame());
    send_beat(sfc_pkg::OP_WRITE, 8'hAA, 16'h5555, random_frame());
    send_beat(sfc_pkg::OP_WRITE, 8'h80, 16'h8000, random_frame());
    idle_gap(1);
  endtask

  // Response checks: extreme frames, good and broken CRC, both signs of the
  // 20-bit data, and the spare opcode that decodes as a check.
  task automatic test_response_checks();
    logic [sfc_pkg::FRAME_W-1:0] g;
    send_beat(sfc_pkg::OP_CHECK, 8'hFF, 16'hFFFF, '0);
    send_beat(sfc_pkg::OP_CHECK, 8'h00, 16'h0000, {sfc_pkg::FRAME_W{1'b1}});
    g = random_frame();
    g[sfc_pkg::DATA_LSB + 19] = 1'b1;
    send_beat(sfc_pkg::OP_CHECK, 8'($urandom()), 16'($urandom()), good_frame(g));
    g[sfc_pkg::DATA_LSB + 19] = 1'b0;
    send_beat(sfc_pkg::OP_CHECK, 8'($urandom()), 16'($urandom()), good_frame(g));
    send_beat(sfc_pkg::OP_CHECK, 8'h00, 16'h0000, good_frame(g) ^ 48'h1);
    send_beat(sfc_pkg::OP_CHECK, 8'h00, 16'h0000, good_frame(g) ^ 48'h8000_0000_0000);
    send_beat(OP_SPARE, 8'hFF, 16'hFFFF, good_frame(random_frame()));
    send_beat(OP_SPARE, 8'h00, 16'h0000, random_frame());
    send_beat(OP_SPARE, 8'h5A, 16'hA5A5, {sfc_pkg::FRAME_W{1'b1}});
    idle_gap(1);
  endtask

  // Random mix of all opcodes in bursts, under one receiver behavior.
  task automatic test_random_mix(int count, ready_mode_t mode, bit with_gaps);
    int                          left;
    int                          burst;
    logic [1:0]                  op;
    logic [sfc_pkg::FRAME_W-1:0] rsp;
    ready_mode = mode;
    left = count;
    while (left > 0) begin
      burst = $urandom_range(1, 30);
      if (burst > left) begin
        burst = left;
      end
      repeat (burst) begin
        op  = 2'($urandom_range(0, 3));
        rsp = random_frame();
        if (op[1] && $urandom_range(0, 1)) begin
          rsp = good_frame(rsp);
        end
        send_beat(op, 8'($urandom()), 16'($urandom()), rsp);
      end
      left -= burst;
      if (with_gaps) begin
        idle_gap($urandom_range(0, 6));
      end
    end
    idle_gap(1);
  endtask

  // Full-rate stream with the receiver always ready.
  task automatic test_back_to_back(int count);
    ready_mode = RDY_ALWAYS;
    repeat (count) begin
      send_beat(2'($urandom_range(0, 3)), 8'($urandom()), 16'($urandom()),
                good_frame(random_frame()));
    end
    idle_gap(1);
  endtask

  // Long receiver hold-off while the sender keeps offering beats.
  task automatic test_output_hold(int count);
    ready_mode = RDY_ALWAYS;
    hold_req   = 1'b1;
    repeat (count) begin
      send_beat(2'($urandom_range(0, 3)), 8'($urandom()), 16'($urandom()),
                random_frame());
    end
    idle_gap(1);
  endtask

  // Watchdog.
  initial begin
    #1000000;
    $display("Some tests failed");
    $finish;
  end

  // Test sequence.
  initial begin
    rst_n              = 1'b0;
    in_valid           = 1'b0;
    in_opcode          = '0;
    in_reg_address     = '0;
    in_write_data      = '0;
    in_response_frame  = '0;
    out_ready          = 1'b0;
    fail_count         = 0;
    beats_checked      = 0;
    crc_good_seen      = 0;
    crc_bad_seen       = 0;
    input_stall_cycles = 0;
    op_sent            = '{default: 0};
    ready_mode         = RDY_PATTERN;
    hold_req           = 1'b0;
    hold_left          = 0;
    run_left           = 0;
    run_ready          = 1'b0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_read_commands();
    test_write_commands();
    test_response_checks();
    wait_drain();
    test_random_mix(250, RDY_ALWAYS, 1'b1);
    test_random_mix(250, RDY_PATTERN, 1'b1);
    test_random_mix(250, RDY_HEAVY, 1'b1);
    test_random_mix(250, RDY_PATTERN, 1'b0);
    wait_drain();
    test_back_to_back(150);
    wait_drain();
    test_output_hold(60);
    wait_drain();

    $display("Covered %0d reads, %0d writes, %0d checks, %0d spare-opcode checks.",
             op_sent[sfc_pkg::OP_READ], op_sent[sfc_pkg::OP_WRITE],
             op_sent[sfc_pkg::OP_CHECK], op_sent[OP_SPARE]);
    $display("Compared %0d result beats (%0d good CRC, %0d bad), input stalled %0d cycles.",
             beats_checked, crc_good_seen, crc_bad_seen, input_stall_cycles);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

FILE: safespi_frame_codec_crc8_top.f
+incdir+src
src/sfc_pkg.sv
src/sfc_codec.sv
src/safespi_frame_codec_crc8_top.sv
src/sfc_checker.sv
tb/tb_safespi_frame_codec_crc8_top.sv
